// ===== hdl/lzss_pkg.sv =====
package lzss_pkg;

  // History window and packing
  localparam int HIST_DEPTH       = 8192;
  localparam int HIST_AW          = $clog2(HIST_DEPTH);
  localparam int LONG_SPAN        = 8192;
  localparam int SHORT_SPAN       = 256;
  localparam int BYTES_PER_RESULT = 4;
  localparam int DIST_W           = 14;
  localparam int LEN_W            = 24;

  // Parser phases
  typedef enum logic [2:0] {
    PH_FIRST     = 3'd0,
    PH_REFILL    = 3'd1,
    PH_LIT       = 3'd2,
    PH_LONG_HI   = 3'd3,
    PH_LONG_LO   = 3'd4,
    PH_LONG_CNT  = 3'd5,
    PH_SHORT_OFF = 3'd6
  } phase_t;

  // Where a flag refill resumes
  localparam logic [1:0] STG_FLAG1      = 2'd0;
  localparam logic [1:0] STG_FLAG2      = 2'd1;
  localparam logic [1:0] STG_SHORT      = 2'd2;
  localparam logic [1:0] STG_SHORT_REST = 2'd3;

  // Register addresses
  localparam logic [1:0] REG_OUTPUT_LENGTH = 2'd0;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_bytes;
    logic [2:0]  byte_count;
    logic        last_of_run;
    logic        stream_done;
  } out_item_t;

endpackage

// ===== hdl/lzss_ram.sv =====
module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/lzss_variable_length_decompressor.sv =====
// Channel   Signals                                  Transaction
// byte      byte_valid, byte_stall, byte_item        one compressed byte in
// result    result_valid, result_stall, result_item  up to four decoded bytes out
// config    psel, penable, pwrite, paddr, pwdata     output_length at address 0
//
// A flag refill or a token byte passes through S_IDLE and S_PROC; a literal
// also passes through S_LIT and S_END. A copy makes one history read and one
// history write per byte through the single-port-read history RAM.
// Synchronous reset clears control state; history needs no clearing since
// a copy only reaches bytes written since the stream began.
// A stalled result holds the sequencer at the next result it must emit.
module lzss_variable_length_decompressor (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     byte_valid,
  output logic                     byte_stall,
  input  lzss_pkg::in_item_t       byte_item,
  output logic                     result_valid,
  input  logic                     result_stall,
  output lzss_pkg::out_item_t      result_item,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [1:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import lzss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROC,
    S_LIT,
    S_CP_RD,
    S_CP_WR,
    S_END
  } state_t;

  typedef struct packed {
    logic [3:0]  fc;
    phase_t      phase;
    logic [15:0] partial;
  } decide_t;

  // Flag-bit decision chain starting at a given stage
  function automatic decide_t decide(input logic [1:0] stage, input logic [7:0] fb,
                                     input logic [3:0] fc_in, input logic [15:0] pt,
                                     input phase_t ph);
    decide_t    r;
    logic [1:0] st;
    logic       dn;
    logic       hi;
    r.fc = fc_in;
    r.phase = ph;
    r.partial = pt;
    st = stage;
    dn = 1'b0;
    hi = 1'b0;
    if (st == STG_FLAG1) begin
      if (r.fc == 4'd0) begin
        r.partial = {6'd0, STG_FLAG1, 8'd0};
        r.phase = PH_REFILL;
        dn = 1'b1;
      end else begin
        r.fc = r.fc - 4'd1;
        if (fb[r.fc[2:0]]) begin
          r.phase = PH_LIT;
          dn = 1'b1;
        end else begin
          st = STG_FLAG2;
        end
      end
    end
    if (!dn && st == STG_FLAG2) begin
      if (r.fc == 4'd0) begin
        r.partial = {6'd0, STG_FLAG2, 8'd0};
        r.phase = PH_REFILL;
        dn = 1'b1;
      end else begin
        r.fc = r.fc - 4'd1;
        if (fb[r.fc[2:0]]) begin
          r.phase = PH_LONG_HI;
          dn = 1'b1;
        end else begin
          st = STG_SHORT;
        end
      end
    end
    if (!dn && st == STG_SHORT) begin
      if (r.fc >= 4'd2) begin
        r.fc = r.fc - 4'd1;
        hi = fb[r.fc[2:0]];
        r.fc = r.fc - 4'd1;
        r.partial = {14'd0, hi, fb[r.fc[2:0]]};
        r.phase = PH_SHORT_OFF;
      end else if (r.fc == 4'd1) begin
        r.fc = 4'd0;
        r.partial = {6'd0, STG_SHORT_REST, 7'd0, fb[0]};
        r.phase = PH_REFILL;
      end else begin
        r.partial = {6'd0, STG_SHORT, 8'd0};
        r.phase = PH_REFILL;
      end
      dn = 1'b1;
    end
    if (!dn && st == STG_SHORT_REST) begin
      r.fc = r.fc - 4'd1;
      r.partial = {14'd0, pt[0], fb[r.fc[2:0]]};
      r.phase = PH_SHORT_OFF;
    end
    return r;
  endfunction

  state_t            state;
  phase_t            phase;
  logic [7:0]        flag_bits;
  logic [3:0]        flag_bit_count;
  logic [15:0]       partial_token;
  logic [LEN_W-1:0]  bytes_written;
  logic              finished;
  logic [LEN_W-1:0]  output_length;
  logic [7:0]        cur_byte;
  logic [DIST_W-1:0] back_dist;
  logic [8:0]        remaining;
  logic              rd_ok;
  logic [31:0]       pack_word;
  logic [2:0]        pack_cnt;

  // Shared emit unit
  logic [7:0]        emit_val;
  logic [LEN_W-1:0]  bw_inc;
  logic              fin_e;
  logic              push_e;
  logic [31:0]       word_e;
  logic              out_free;
  logic              emit_last;
  logic              res_load;
  logic [HIST_AW-1:0] rd_addr;
  logic [LEN_W-1:0]  back_pos;
  logic [7:0]        rd_data;
  logic              hist_we;
  decide_t           dec_first;
  decide_t           dec_refill;

  assign out_free = !result_valid || !result_stall;
  assign emit_val = (state == S_LIT) ? cur_byte : (rd_ok ? rd_data : 8'd0);
  assign bw_inc   = bytes_written + LEN_W'(1);
  assign fin_e    = bw_inc >= output_length;
  assign push_e   = (pack_cnt == 3'(BYTES_PER_RESULT - 1)) || fin_e;
  assign word_e   = pack_word | (32'(emit_val) << {pack_cnt, 3'b000});
  assign emit_last = fin_e || (state == S_LIT) || (remaining == 9'd1);
  assign back_pos = bytes_written - LEN_W'(back_dist);
  assign rd_addr  = back_pos[HIST_AW-1:0];
  assign hist_we  = ((state == S_LIT) || (state == S_CP_WR)) && (!push_e || out_free);

  // A new result is loaded into the output register this cycle
  assign res_load = out_free && (
      (state == S_PROC && phase == PH_LONG_CNT && cur_byte == 8'd0) ||
      ((state == S_LIT || state == S_CP_WR) && push_e) ||
      (state == S_END && pack_cnt != 3'd0));

  assign dec_first  = decide(STG_FLAG1, flag_bits, flag_bit_count, partial_token, phase);
  assign dec_refill = decide(partial_token[9:8], cur_byte, 4'd8, partial_token, phase);

  assign byte_stall = (state != S_IDLE);
  assign pready     = 1'b1;
  assign prdata     = {8'd0, output_length};

  lzss_ram #(.WIDTH(8), .DEPTH(HIST_DEPTH)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (bytes_written[HIST_AW-1:0]),
    .wdata (emit_val),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Sequencer, parser state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      phase          <= PH_FIRST;
      flag_bits      <= 8'd0;
      flag_bit_count <= 4'd0;
      partial_token  <= 16'd0;
      bytes_written  <= '0;
      finished       <= 1'b0;
      output_length  <= LEN_W'(1);
      result_valid   <= 1'b0;
      pack_word      <= 32'd0;
      pack_cnt       <= 3'd0;
    end else begin
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (psel && penable && pwrite && paddr == REG_OUTPUT_LENGTH) begin
        output_length <= pwdata[LEN_W-1:0];
      end
      case (state)
        S_IDLE: begin
          pack_word <= 32'd0;
          pack_cnt  <= 3'd0;
          if (byte_valid) begin
            cur_byte <= byte_item.in_byte;
            if (byte_item.start_of_stream) begin
              phase          <= PH_FIRST;
              flag_bits      <= 8'd0;
              flag_bit_count <= 4'd0;
              partial_token  <= 16'd0;
              bytes_written  <= '0;
              finished       <= 1'b0;
              state          <= S_PROC;
            end else if (!finished) begin
              state <= S_PROC;
            end
          end
        end
        S_PROC: begin
          case (phase)
            PH_REFILL: begin
              flag_bits      <= cur_byte;
              flag_bit_count <= dec_refill.fc;
              phase          <= dec_refill.phase;
              partial_token  <= dec_refill.partial;
              state          <= S_IDLE;
            end
            PH_LONG_HI: begin
              partial_token <= {8'd0, cur_byte};
              phase         <= PH_LONG_LO;
              state         <= S_IDLE;
            end
            PH_LONG_LO: begin
              partial_token <= {partial_token[7:0], cur_byte};
              if (cur_byte[2:0] != 3'd0) begin
                back_dist <= DIST_W'(LONG_SPAN) - {1'b0, partial_token[7:0], cur_byte[7:3]};
                remaining <= {6'd0, cur_byte[2:0]} + 9'd2;
                state     <= S_CP_RD;
              end else begin
                phase <= PH_LONG_CNT;
                state <= S_IDLE;
              end
            end
            PH_LONG_CNT: begin
              if (cur_byte == 8'd0) begin
                // End marker: a single empty result
                if (out_free) begin
                  finished                 <= 1'b1;
                  result_item.out_bytes    <= 32'd0;
                  result_item.byte_count   <= 3'd0;
                  result_item.last_of_run  <= 1'b1;
                  result_item.stream_done  <= 1'b1;
                  state                    <= S_IDLE;
                end
              end else begin
                back_dist <= DIST_W'(LONG_SPAN) - {1'b0, partial_token[15:3]};
                remaining <= {1'b0, cur_byte} + 9'd1;
                state     <= S_CP_RD;
              end
            end
            PH_SHORT_OFF: begin
              back_dist <= DIST_W'(SHORT_SPAN) - {6'd0, cur_byte};
              remaining <= {7'd0, partial_token[1:0]} + 9'd2;
              state     <= S_CP_RD;
            end
            default: begin
              state <= S_LIT;
            end
          endcase
        end
        S_CP_RD: begin
          // Issue one history read; bytes not yet written read as zero
          if (finished || remaining == 9'd0) begin
            state <= S_END;
          end else begin
            rd_ok <= (LEN_W'(back_dist) <= bytes_written);
            state <= S_CP_WR;
          end
        end
        S_LIT, S_CP_WR: begin
          if (!push_e || out_free) begin
            bytes_written <= bw_inc;
            finished      <= fin_e;
            remaining     <= remaining - 9'd1;
            if (push_e) begin
              result_item.out_bytes   <= word_e;
              result_item.byte_count  <= pack_cnt + 3'd1;
              result_item.last_of_run <= emit_last;
              result_item.stream_done <= fin_e;
              pack_word               <= 32'd0;
              pack_cnt                <= 3'd0;
            end else begin
              pack_word <= word_e;
              pack_cnt  <= pack_cnt + 3'd1;
            end
            state <= (state == S_LIT) ? S_END : S_CP_RD;
          end
        end
        S_END: begin
          // Flush a partial word, then read the next flags unless the stream is finished
          if (pack_cnt == 3'd0 || out_free) begin
            if (pack_cnt != 3'd0) begin
              result_item.out_bytes   <= pack_word;
              result_item.byte_count  <= pack_cnt;
              result_item.last_of_run <= 1'b1;
              result_item.stream_done <= finished;
            end
            if (!finished) begin
              flag_bit_count <= dec_first.fc;
              phase          <= dec_first.phase;
              partial_token  <= dec_first.partial;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/lzss_checker.sv =====
module lzss_checker (
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_stall,
  input lzss_pkg::out_item_t result_item
);
  import lzss_pkg::*;

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("stalled result changed");

  // Empty result only for the end marker
  a_empty: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.byte_count == 3'd0 |->
      result_item.stream_done && result_item.last_of_run)
    else $error("empty result outside end marker");

  // Stream end closes the run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.stream_done |-> result_item.last_of_run)
    else $error("stream done without last of run");

  // Count bounded by packing width
  a_count: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_item.byte_count <= 3'(BYTES_PER_RESULT))
    else $error("byte count too large");

endmodule

bind lzss_variable_length_decompressor lzss_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_item  (result_item)
);
